// File: design/ktaf_pkg.sv
// ----------------------------------------------------------------------------
// ktaf_pkg
// Shared types, codes and helpers for the tilt-angle Kalman fusion block.
// ----------------------------------------------------------------------------
package ktaf_pkg;

   // fixed formats
   localparam int DT_FRAC    = 24;  // time step is unsigned Q0.24
   localparam int MA_W       = 33;  // multiplier operand a
   localparam int MB_W       = 35;  // multiplier operand b
   localparam int PROD_W     = MA_W + MB_W;
   localparam int TERM_W     = 48;  // rounded product
   localparam int ACC_W      = 50;  // update sum before saturation
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 31;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_LOCK_LIMIT  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_START_VAR   = 3'd5;

   // register reset values
   localparam logic [23:0] RST_TIME_STEP   = 24'd83886;
   localparam logic [30:0] RST_ANGLE_NOISE = 31'd16777;
   localparam logic [30:0] RST_BIAS_NOISE  = 31'd50332;
   localparam logic [30:0] RST_MEAS_NOISE  = 31'd503316;
   localparam logic [23:0] RST_LOCK_LIMIT  = 24'd2949120;
   localparam logic [30:0] RST_START_VAR   = 31'd16777216;

   // request kinds
   localparam logic [1:0] REQ_PREDICT = 2'd0;
   localparam logic [1:0] REQ_MEASURE = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // multiplier operand pairs
   localparam logic [2:0] MUL_RATE_DT  = 3'd0;
   localparam logic [2:0] MUL_DT_VB    = 3'd1;
   localparam logic [2:0] MUL_DT_INNER = 3'd2;
   localparam logic [2:0] MUL_K0_INN   = 3'd3;
   localparam logic [2:0] MUL_K1_INN   = 3'd4;
   localparam logic [2:0] MUL_K1_CC    = 3'd5;
   localparam logic [2:0] MUL_K0_CC    = 3'd6;
   localparam logic [2:0] MUL_K0_VA    = 3'd7;

   // state updates
   localparam logic [3:0] UPD_NONE      = 4'd0;
   localparam logic [3:0] UPD_ANGLE_ADD = 4'd1;
   localparam logic [3:0] UPD_TMP       = 4'd2;
   localparam logic [3:0] UPD_VA_PRED   = 4'd3;
   localparam logic [3:0] UPD_PRED_TAIL = 4'd4;
   localparam logic [3:0] UPD_LOCK      = 4'd5;
   localparam logic [3:0] UPD_INNOV     = 4'd6;
   localparam logic [3:0] UPD_BIAS_ADD  = 4'd7;
   localparam logic [3:0] UPD_VB_SUB    = 4'd8;
   localparam logic [3:0] UPD_CC_SUB    = 4'd9;
   localparam logic [3:0] UPD_VA_SUB    = 4'd10;
   localparam logic [3:0] UPD_RESTART   = 4'd11;

   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic [2:0] mul_op;
      logic       rnd_en;
      logic       rnd_cov;
      logic [3:0] upd_op;
      logic       div_start;
      logic       out_load;
   } ktaf_cmd_type;

   typedef struct packed {
      logic lock;
      logic lock_ok;
      logic div_done;
   } ktaf_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      if (x[ACC_W-1:31] == '0 || x[ACC_W-1:31] == '1) begin
         return x[31:0];
      end else if (x[ACC_W-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

endpackage

// File: design/kalman_tilt_angle_fusion_top.sv
// ----------------------------------------------------------------------------
// kalman_tilt_angle_fusion_top
// Two-state (roll angle, gyro bias) Kalman filter fusing gyro and accel.
// ----------------------------------------------------------------------------
// One item at a time. A predict item (tuser 0) runs from accept to result as
// three multiply, round and update passes through the single shared
// multiplier plus a covariance tail and the output load. A measure item
// (tuser 1) runs a lock check and an innovation step, then the gain divider,
// which produces one quotient bit per cycle for both gains at once; five
// multiply passes follow it. A measure that fails the lock check and an
// unused kind go straight to the output load, a restart after its reset
// step. A stalled result holds the sequencer in its last step until the
// output register is free. A finished result sits in the output register,
// so the next item is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module kalman_tilt_angle_fusion_top #(
   parameter int COV_FRAC_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // roll_estimate, bias_estimate, locked
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   import ktaf_pkg::*;

   ktaf_cmd_type    cmd;
   ktaf_status_type status;

   ktaf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ktaf_dp #(
      .COV_FRAC_BITS (COV_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample    (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule

// File: design/ktaf_div.sv
// ----------------------------------------------------------------------------
// ktaf_div
// Bit-serial gain divider: two signed quotients over one shared divisor,
// one quotient bit per cycle, saturated to 32 bits, zero for a zero divisor.
// ----------------------------------------------------------------------------
module ktaf_div #(
   parameter int FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num0,
   input  logic signed [31:0] num1,
   input  logic signed [32:0] den,
   output logic               done,
   output logic signed [31:0] quo0,
   output logic signed [31:0] quo1
);
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, fix_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [32:0]      den_ff, rem0_ff, rem1_ff, rem0_in, rem1_in;
   logic [NUM_W-1:0] nq0_ff, nq1_ff, nq0_in, nq1_in;
   logic             neg0_ff, neg1_ff, zero_ff;
   logic signed [31:0] quo0_ff, quo1_ff;
   logic [33:0]      sh0, sh1, dif0, dif1;
   logic             ge0, ge1;
   logic [31:0]      mag0, mag1;
   logic [32:0]      den_mag;

   function automatic logic signed [31:0] fix_quo(input logic [NUM_W-1:0] q, input logic neg);
      logic over_p, over_n;
      over_p = |q[NUM_W-1:31];
      over_n = (|q[NUM_W-1:32]) | (q[31] & (|q[30:0]));
      if (neg) begin
         return over_n ? 32'sh8000_0000 : $signed(-q[31:0]);
      end else begin
         return over_p ? 32'sh7fff_ffff : $signed(q[31:0]);
      end
   endfunction

   always_comb begin
      mag0    = num0[31] ? -num0 : num0;
      mag1    = num1[31] ? -num1 : num1;
      den_mag = den[32] ? -den : den;
      // restoring step on both lanes
      sh0     = {rem0_ff, nq0_ff[NUM_W-1]};
      sh1     = {rem1_ff, nq1_ff[NUM_W-1]};
      dif0    = sh0 - {1'b0, den_ff};
      dif1    = sh1 - {1'b0, den_ff};
      ge0     = sh0 >= {1'b0, den_ff};
      ge1     = sh1 >= {1'b0, den_ff};
      rem0_in = ge0 ? dif0[32:0] : sh0[32:0];
      rem1_in = ge1 ? dif1[32:0] : sh1[32:0];
      nq0_in  = {nq0_ff[NUM_W-2:0], ge0};
      nq1_in  = {nq1_ff[NUM_W-2:0], ge1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               fix_ff  <= 1'b1;
            end
         end else if (fix_ff) begin
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff  <= den_mag;
         rem0_ff <= '0;
         rem1_ff <= '0;
         nq0_ff  <= {mag0, {FRAC_BITS{1'b0}}};
         nq1_ff  <= {mag1, {FRAC_BITS{1'b0}}};
         neg0_ff <= num0[31] ^ den[32];
         neg1_ff <= num1[31] ^ den[32];
         zero_ff <= (den == '0);
      end else if (busy_ff) begin
         rem0_ff <= rem0_in;
         rem1_ff <= rem1_in;
         nq0_ff  <= nq0_in;
         nq1_ff  <= nq1_in;
      end
      if (fix_ff) begin
         quo0_ff <= zero_ff ? 32'sd0 : fix_quo(nq0_ff, neg0_ff);
         quo1_ff <= zero_ff ? 32'sd0 : fix_quo(nq1_ff, neg1_ff);
      end
   end

   assign done = done_ff;
   assign quo0 = quo0_ff;
   assign quo1 = quo1_ff;

endmodule

// File: design/ktaf_dp.sv
// ----------------------------------------------------------------------------
// ktaf_dp
// Datapath: settings, filter state, shared multiplier with rounding stage,
// gain divider and the result register.
// ----------------------------------------------------------------------------
module ktaf_dp #(
   parameter int COV_FRAC_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [2:0]                 csr_index,
   input  logic [30:0]                csr_wdata,
   input  logic [31:0]                sample,
   input  ktaf_pkg::ktaf_cmd_type     cmd,
   output ktaf_pkg::ktaf_status_type  status,
   output logic [71:0]                rsp_data
);
   import ktaf_pkg::*;

   localparam logic signed [PROD_W-1:0] HALF_DT  = PROD_W'(1) <<< (DT_FRAC - 1);
   localparam logic signed [PROD_W-1:0] HALF_COV = PROD_W'(1) <<< (COV_FRAC_BITS - 1);

   logic [23:0] dt_ff, lim_ff;
   logic [30:0] qa_ff, qb_ff, rn_ff, svar_ff;

   logic signed [31:0] sample_ff, angle_ff, bias_ff, va_ff, cc_ff, vb_ff, tmp_ff;
   logic               lock_ff;
   logic signed [PROD_W-1:0] prod_ff, prod, sum_dt, sum_cov, rnd_dt, rnd_cov;
   logic signed [TERM_W-1:0] term_ff;
   logic signed [MA_W-1:0]   mul_a, dt_a;
   logic signed [MB_W-1:0]   mul_b, inner;
   logic signed [32:0]       rate_diff, smp33, den;
   logic [32:0]              mag;
   logic signed [31:0]       k0, k1;
   logic                     div_done;
   logic [64:0]              out_ff;

   logic signed [ACC_W-1:0] e_angle, e_bias, e_va, e_cc, e_vb, e_tmp, e_term, e_smp;
   logic signed [ACC_W-1:0] e_qa, e_qb;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= RST_TIME_STEP;
         qa_ff   <= RST_ANGLE_NOISE;
         qb_ff   <= RST_BIAS_NOISE;
         rn_ff   <= RST_MEAS_NOISE;
         lim_ff  <= RST_LOCK_LIMIT;
         svar_ff <= RST_START_VAR;
      end else if (csr_wr_en) begin
         case (csr_index)
            CFG_TIME_STEP:   dt_ff   <= csr_wdata[23:0];
            CFG_ANGLE_NOISE: qa_ff   <= csr_wdata;
            CFG_BIAS_NOISE:  qb_ff   <= csr_wdata;
            CFG_MEAS_NOISE:  rn_ff   <= csr_wdata;
            CFG_LOCK_LIMIT:  lim_ff  <= csr_wdata[23:0];
            CFG_START_VAR:   svar_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample;
      end
   end

   // multiplier operand select
   always_comb begin
      dt_a      = $signed({{(MA_W-24){1'b0}}, dt_ff});
      rate_diff = $signed({sample_ff[31], sample_ff}) - $signed({bias_ff[31], bias_ff});
      inner     = $signed({{3{tmp_ff[31]}}, tmp_ff}) - $signed({{2{cc_ff[31]}}, cc_ff, 1'b0});
      case (cmd.mul_op)
         MUL_RATE_DT: begin
            mul_a = rate_diff;
            mul_b = $signed({{(MB_W-24){1'b0}}, dt_ff});
         end
         MUL_DT_VB: begin
            mul_a = dt_a;
            mul_b = MB_W'(vb_ff);
         end
         MUL_DT_INNER: begin
            mul_a = dt_a;
            mul_b = inner;
         end
         MUL_K0_INN: begin
            mul_a = MA_W'(k0);
            mul_b = MB_W'(tmp_ff);
         end
         MUL_K1_INN: begin
            mul_a = MA_W'(k1);
            mul_b = MB_W'(tmp_ff);
         end
         MUL_K1_CC: begin
            mul_a = MA_W'(k1);
            mul_b = MB_W'(cc_ff);
         end
         MUL_K0_CC: begin
            mul_a = MA_W'(k0);
            mul_b = MB_W'(cc_ff);
         end
         MUL_K0_VA: begin
            mul_a = MA_W'(k0);
            mul_b = MB_W'(va_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod    = mul_a * mul_b;
   // round half up, then arithmetic shift
   assign sum_dt  = prod_ff + HALF_DT;
   assign sum_cov = prod_ff + HALF_COV;
   assign rnd_dt  = sum_dt >>> DT_FRAC;
   assign rnd_cov = sum_cov >>> COV_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod;
      end
      if (cmd.rnd_en) begin
         term_ff <= cmd.rnd_cov ? rnd_cov[TERM_W-1:0] : rnd_dt[TERM_W-1:0];
      end
   end

   // widened operands for the update sums
   always_comb begin
      e_angle = ACC_W'(angle_ff);
      e_bias  = ACC_W'(bias_ff);
      e_va    = ACC_W'(va_ff);
      e_cc    = ACC_W'(cc_ff);
      e_vb    = ACC_W'(vb_ff);
      e_tmp   = ACC_W'(tmp_ff);
      e_smp   = ACC_W'(sample_ff);
      e_term  = ACC_W'(term_ff);
      e_qa    = $signed({{(ACC_W-31){1'b0}}, qa_ff});
      e_qb    = $signed({{(ACC_W-31){1'b0}}, qb_ff});
      smp33   = $signed({sample_ff[31], sample_ff});
      mag     = sample_ff[31] ? -smp33 : smp33;
      den     = $signed({va_ff[31], va_ff}) + $signed({2'b00, rn_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         bias_ff  <= '0;
         va_ff    <= $signed({1'b0, RST_START_VAR});
         cc_ff    <= '0;
         vb_ff    <= $signed({1'b0, RST_START_VAR});
         lock_ff  <= 1'b0;
      end else begin
         case (cmd.upd_op)
            UPD_ANGLE_ADD: angle_ff <= sat32(e_angle + e_term);
            UPD_BIAS_ADD:  bias_ff  <= sat32(e_bias + e_term);
            UPD_VA_PRED:   va_ff    <= sat32(e_va + e_term + e_qa);
            UPD_PRED_TAIL: begin
               cc_ff <= sat32(e_cc - e_tmp);
               vb_ff <= sat32(e_vb + e_qb);
            end
            UPD_LOCK: begin
               if (!lock_ff) begin
                  bias_ff <= '0;
                  if (mag <= {9'b0, lim_ff}) begin
                     angle_ff <= sample_ff;
                     lock_ff  <= 1'b1;
                  end else begin
                     angle_ff <= '0;
                  end
               end
            end
            UPD_VB_SUB:    vb_ff <= sat32(e_vb - e_term);
            UPD_CC_SUB:    cc_ff <= sat32(e_cc - e_term);
            UPD_VA_SUB:    va_ff <= sat32(e_va - e_term);
            UPD_RESTART: begin
               angle_ff <= '0;
               bias_ff  <= '0;
               va_ff    <= $signed({1'b0, svar_ff});
               cc_ff    <= '0;
               vb_ff    <= $signed({1'b0, svar_ff});
               lock_ff  <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // scratch: t during predict, innovation during measure
   always_ff @(posedge clock) begin
      if (cmd.upd_op == UPD_TMP) begin
         tmp_ff <= term_ff[31:0];
      end else if (cmd.upd_op == UPD_INNOV) begin
         tmp_ff <= sat32(e_smp - e_angle);
      end
   end

   ktaf_div #(
      .FRAC_BITS (COV_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num0  (va_ff),
      .num1  (cc_ff),
      .den   (den),
      .done  (div_done),
      .quo0  (k0),
      .quo1  (k1)
   );

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= {lock_ff, bias_ff, angle_ff};
      end
   end

   assign rsp_data        = {7'b0, out_ff};
   assign status.lock     = lock_ff;
   assign status.lock_ok  = (mag <= {9'b0, lim_ff});
   assign status.div_done = div_done;

endmodule

// File: design/ktaf_ctrl.sv
// ----------------------------------------------------------------------------
// ktaf_ctrl
// Sequencer: steps a measure item through lock check, gain division and the
// multiply / round / update passes, then hands the result to the output.
// ----------------------------------------------------------------------------
module ktaf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [1:0]                 req_type,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  ktaf_pkg::ktaf_status_type  status,
   output ktaf_pkg::ktaf_cmd_type     cmd
);
   import ktaf_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LOCK     = 4'd1;
   localparam logic [3:0] S_INNOV    = 4'd2;
   localparam logic [3:0] S_DIV_GO   = 4'd3;
   localparam logic [3:0] S_DIV_WAIT = 4'd4;
   localparam logic [3:0] S_MUL      = 4'd5;
   localparam logic [3:0] S_RND      = 4'd6;
   localparam logic [3:0] S_UPD      = 4'd7;
   localparam logic [3:0] S_TAIL     = 4'd8;
   localparam logic [3:0] S_RESTART  = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   localparam logic [2:0] LAST_PRED = 3'd2;
   localparam logic [2:0] LAST_MEAS = 3'd4;

   logic [3:0] state_ff, state_in;
   logic       meas_ff, meas_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   function automatic logic [2:0] step_mul(input logic meas, input logic [2:0] step);
      if (!meas) begin
         case (step)
            3'd0:    return MUL_RATE_DT;
            3'd1:    return MUL_DT_VB;
            default: return MUL_DT_INNER;
         endcase
      end else begin
         case (step)
            3'd0:    return MUL_K0_INN;
            3'd1:    return MUL_K1_INN;
            3'd2:    return MUL_K1_CC;
            3'd3:    return MUL_K0_CC;
            default: return MUL_K0_VA;
         endcase
      end
   endfunction

   // old covariances are read before they are overwritten
   function automatic logic [3:0] step_upd(input logic meas, input logic [2:0] step);
      if (!meas) begin
         case (step)
            3'd0:    return UPD_ANGLE_ADD;
            3'd1:    return UPD_TMP;
            default: return UPD_VA_PRED;
         endcase
      end else begin
         case (step)
            3'd0:    return UPD_ANGLE_ADD;
            3'd1:    return UPD_BIAS_ADD;
            3'd2:    return UPD_VB_SUB;
            3'd3:    return UPD_CC_SUB;
            default: return UPD_VA_SUB;
         endcase
      end
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_op   = step_mul(meas_ff, step_ff);
      cmd.rnd_cov  = meas_ff;
      state_in     = state_ff;
      meas_in      = meas_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               case (req_type)
                  REQ_PREDICT: begin
                     meas_in  = 1'b0;
                     state_in = S_MUL;
                  end
                  REQ_MEASURE: begin
                     meas_in  = 1'b1;
                     state_in = S_LOCK;
                  end
                  REQ_RESTART: state_in = S_RESTART;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_LOCK: begin
            cmd.upd_op = UPD_LOCK;
            state_in   = (!status.lock && !status.lock_ok) ? S_DONE : S_INNOV;
         end
         S_INNOV: begin
            cmd.upd_op = UPD_INNOV;
            state_in   = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_RND;
         end
         S_RND: begin
            cmd.rnd_en = 1'b1;
            state_in   = S_UPD;
         end
         S_UPD: begin
            cmd.upd_op = step_upd(meas_ff, step_ff);
            if (step_ff == (meas_ff ? LAST_MEAS : LAST_PRED)) begin
               state_in = meas_ff ? S_DONE : S_TAIL;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = S_MUL;
            end
         end
         S_TAIL: begin
            cmd.upd_op = UPD_PRED_TAIL;
            state_in   = S_DONE;
         end
         S_RESTART: begin
            cmd.upd_op = UPD_RESTART;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // wait for the output slot to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         meas_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         meas_ff      <= meas_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending item");

   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished while not awaited");

   a_item_taken: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item not started");

endmodule
